### hdl/b32d_pkg.sv
// Shared types, character constants and status codes for the base32 stream decoder.
package b32d_pkg;

   localparam logic [7:0] CHAR_DIGIT_LO = 8'h32;
   localparam logic [7:0] CHAR_DIGIT_HI = 8'h37;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
   localparam logic [7:0] CHAR_UPPER_HI = 8'h5A;
   localparam logic [7:0] CHAR_PAD      = 8'h3D;
   localparam logic [7:0] DIGIT_OFFSET  = 8'd24;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;
   localparam logic [1:0] STATUS_BAD_PAD   = 2'd3;

   localparam logic [3:0] PAD_COUNT_MAX = 4'd15;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       byte_valid;
      logic       stream_done;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic       is_data;
      logic       is_pad;
      logic [4:0] value;
   } sym_info_type;

   typedef struct packed {
      logic    present;
      rsp_type beat;
   } step_result_type;

endpackage

### hdl/b32d_sym_map.sv
// Maps one ASCII character to its base32 symbol value and class.
module b32d_sym_map (
   input  logic [7:0]            char_in,
   output b32d_pkg::sym_info_type info
);

   logic is_digit;
   logic is_upper;
   logic [7:0] digit_val;
   logic [7:0] upper_val;

   assign is_digit  = (char_in >= b32d_pkg::CHAR_DIGIT_LO) && (char_in <= b32d_pkg::CHAR_DIGIT_HI);
   assign is_upper  = (char_in >= b32d_pkg::CHAR_UPPER_LO) && (char_in <= b32d_pkg::CHAR_UPPER_HI);
   assign digit_val = char_in - b32d_pkg::CHAR_ZERO + b32d_pkg::DIGIT_OFFSET;
   assign upper_val = char_in - b32d_pkg::CHAR_UPPER_LO;

   always_comb begin
      info.is_data = is_digit || is_upper;
      info.is_pad  = (char_in == b32d_pkg::CHAR_PAD);
      info.value   = is_digit ? digit_val[4:0] : upper_val[4:0];
   end

endmodule

### hdl/b32d_core.sv
// Stream state of the decoder and the per-character update that forms each result.
module b32d_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  b32d_pkg::req_type         item,
   output b32d_pkg::step_result_type result
);

   b32d_pkg::sym_info_type sym;

   logic [11:0] buf_ff, buf_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [2:0]  grp_ff, grp_in;
   logic [3:0]  pad_ff, pad_in;
   logic [1:0]  err_ff, err_in;

   logic [11:0] buf_shift;
   logic [3:0]  cnt_sum;
   logic [3:0]  rem;
   logic [11:0] byte_wide;
   logic [7:0]  byte_val;
   logic        have_byte;
   logic        pad_ok;
   logic [1:0]  status;

   b32d_sym_map u_sym_map (
      .char_in (item.char_in),
      .info    (sym)
   );

   always_comb begin
      buf_in    = buf_ff;
      cnt_in    = cnt_ff;
      grp_in    = grp_ff + 3'd1;
      pad_in    = pad_ff;
      err_in    = err_ff;
      buf_shift = {buf_ff[6:0], sym.value};
      cnt_sum   = cnt_ff + 4'd5;
      rem       = cnt_sum - 4'd8;
      byte_wide = buf_shift >> rem;
      byte_val  = 8'd0;
      have_byte = 1'b0;
      if (sym.is_pad) begin
         if (pad_ff != b32d_pkg::PAD_COUNT_MAX) begin
            pad_in = pad_ff + 4'd1;
         end
         buf_in = 12'd0;
         cnt_in = 4'd0;
      end else if (!sym.is_data || (pad_ff != 4'd0)) begin
         if (err_ff == b32d_pkg::STATUS_OK) begin
            err_in = b32d_pkg::STATUS_BAD_CHAR;
         end
      end else if (cnt_sum >= 4'd8) begin
         cnt_in    = rem;
         byte_val  = byte_wide[7:0];
         buf_in    = buf_shift & ((12'd1 << rem) - 12'd1);
         have_byte = (err_ff == b32d_pkg::STATUS_OK);
      end else begin
         cnt_in = cnt_sum;
         buf_in = buf_shift;
      end

      pad_ok = (pad_in == 4'd0) || (pad_in == 4'd1) || (pad_in == 4'd3) ||
               (pad_in == 4'd4) || (pad_in == 4'd6);
      if (grp_in != 3'd0) begin
         status = b32d_pkg::STATUS_BAD_LEN;
      end else if (!pad_ok) begin
         status = b32d_pkg::STATUS_BAD_PAD;
      end else begin
         status = err_in;
      end

      result = '0;
      if (item.end_of_stream) begin
         result.present          = 1'b1;
         result.beat.stream_done = 1'b1;
         result.beat.status      = status;
         result.beat.byte_valid  = have_byte && (status == b32d_pkg::STATUS_OK);
         result.beat.byte_out    = result.beat.byte_valid ? byte_val : 8'd0;
         buf_in = 12'd0;
         cnt_in = 4'd0;
         grp_in = 3'd0;
         pad_in = 4'd0;
         err_in = b32d_pkg::STATUS_OK;
      end else if (have_byte) begin
         result.present         = 1'b1;
         result.beat.byte_valid = 1'b1;
         result.beat.byte_out   = byte_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= 12'd0;
         cnt_ff <= 4'd0;
         grp_ff <= 3'd0;
         pad_ff <= 4'd0;
         err_ff <= b32d_pkg::STATUS_OK;
      end else if (step) begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
         grp_ff <= grp_in;
         pad_ff <= pad_in;
         err_ff <= err_in;
      end
   end

endmodule

### hdl/base32_stream_decoder.sv
// Top level of the base32 stream decoder with its input and result registers.
//
// The request channel takes one ASCII character per beat together with an
// end-of-stream flag. The response channel returns a decoded byte whenever
// eight data bits have gathered, and one final beat for the end-of-stream
// character that carries the stream status (ok, bad character, bad length or
// bad padding count) and, when the status is ok, any byte completed by it.
// Characters that complete no byte and do not end the stream return nothing.
// An accepted request beat passes the input register and then the result
// register. One character is accepted every cycle while nothing stalls; the
// rate is set by the single decode step between the two registers.
// Reset clears all stream state and empties both registers. When the
// receiver stalls, the result beat holds, and the request side stalls as
// soon as a character waits in the input register behind it.
// After the end-of-stream beat the state is cleared for the next stream.
module base32_stream_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b32d_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b32d_pkg::rsp_type rsp_data
);

   logic                      in_valid_ff;
   b32d_pkg::req_type         in_data_ff;
   logic                      out_valid_ff, out_valid_in;
   b32d_pkg::rsp_type         out_data_ff;
   logic                      out_free;
   logic                      step;
   b32d_pkg::step_result_type result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   b32d_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .result (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = step && result.present;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (step && result.present) begin
         out_data_ff <= result.beat;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### hdl/b32d_checker.sv
// Port checker for the base32 stream decoder and its bind statement.
module b32d_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input b32d_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("A stalled response beat changed.");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.stream_done |-> rsp_data.status == b32d_pkg::STATUS_OK)
      else $error("A status was reported before the end of the stream.");

   a_mid_beat_has_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.stream_done |-> rsp_data.byte_valid)
      else $error("A response beat carried neither a byte nor the end of the stream.");

   a_no_byte_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != b32d_pkg::STATUS_OK |-> !rsp_data.byte_valid)
      else $error("A byte was delivered with a failing stream status.");

   a_empty_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.byte_out == 8'd0)
      else $error("An empty byte field was not zero.");

endmodule

bind base32_stream_decoder b32d_checker u_b32d_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
